FILE: hdl/lseg_pkg.sv
// ----------------------------------------------------------------------------
// lseg_pkg: shared types and constants of the LED strip effect generator
// Holds the effect codes, register indexes, fixed-point constants and the
// sine table entry function used to build the breathe table.
// ----------------------------------------------------------------------------
package lseg_pkg;

	localparam int IDX_W = 8;
	localparam int CNT_W = 9;

	// effect codes
	localparam logic [3:0] MODE_SOLID    = 4'd0;
	localparam logic [3:0] MODE_BLINK    = 4'd1;
	localparam logic [3:0] MODE_GRADIENT = 4'd2;
	localparam logic [3:0] MODE_RAINBOW  = 4'd3;
	localparam logic [3:0] MODE_CHASE    = 4'd4;
	localparam logic [3:0] MODE_BREATHE  = 4'd5;
	localparam logic [3:0] MODE_STROBE   = 4'd6;
	localparam logic [3:0] MODE_COMET    = 4'd7;
	localparam logic [3:0] MODE_WIPE     = 4'd8;
	localparam logic [3:0] MODE_THEATER  = 4'd9;

	// register indexes
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_COLOR  = 2'd1;
	localparam logic [1:0] REG_PERIOD = 2'd2;
	localparam logic [1:0] REG_COUNT  = 2'd3;

	localparam logic [31:0] BREATHE_STEP = 32'd2050696;
	localparam logic [16:0] HUE_FULL     = 17'd92160;
	localparam logic [16:0] HUE_SECTOR   = 17'd15360;
	localparam logic [11:0] HUE_STEP     = 12'd2560;
	localparam logic [14:0] RECIP_60     = 15'd17477;
	localparam logic [3:0]  COMET_LEN    = 4'd8;
	localparam logic [9:0]  CHASE_LEN    = 10'd3;

	typedef struct packed {
		logic [3:0]       mode;
		logic [31:0]      color;
		logic [CNT_W-1:0] n;
	} cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0] i;
		logic [7:0]       level;
		logic [1:0]       p_lo;
		logic [7:0]       tq;
		logic [16:0]      hq;
		logic [9:0]       f2n;
		logic [5:0]       pm36;
		logic [1:0]       pm3;
		logic [1:0]       im3;
	} fx_in_t;

	// one sine table entry in Q0.8, offset to 0..255
	function automatic logic [7:0] sine_entry(input int quad, input longint x0);
		longint x;
		longint x2;
		longint r;
		longint s;
		longint e;
		x = x0;
		if ((quad % 2) == 1) x = 65536 - x;
		x2 = (x * x) / 65536;
		r = 11;
		r = -307 + (r * x2) / 65536;
		r = 5223 + (r * x2) / 65536;
		r = -42334 + (r * x2) / 65536;
		r = 102944 + (r * x2) / 65536;
		s = (r * x) / 65536;
		if (s < 0) s = 0;
		if (s > 65536) s = 65536;
		if (quad >= 2) s = -s;
		e = ((65536 + s) * 128) / 65536;
		if (e > 255) e = 255;
		return 8'(e);
	endfunction

endpackage

FILE: hdl/lseg_ram.sv
// ----------------------------------------------------------------------------
// lseg_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lseg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

FILE: hdl/lseg_div.sv
// ----------------------------------------------------------------------------
// lseg_div: pipelined restoring divider
// One quotient bit per stage, NW stages; a sideband word travels alongside.
// ----------------------------------------------------------------------------
module lseg_div #(
	parameter int NW = 32,
	parameter int DW = 16,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side,
	output logic          out_valid,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem,
	output logic [SW-1:0] side_out
);

	logic          v_s  [NW];
	logic [NW-1:0] w_s  [NW];
	logic [DW-1:0] r_s  [NW];
	logic [DW-1:0] d_s  [NW];
	logic [SW-1:0] sd_s [NW];

	for (genvar j = 0; j < NW; j++) begin : g_stg
		logic          v_in;
		logic [NW-1:0] w_in;
		logic [DW-1:0] r_in;
		logic [DW-1:0] d_in;
		logic [SW-1:0] sd_in;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          ge;

		if (j == 0) begin : g_first
			assign v_in  = in_valid;
			assign w_in  = num;
			assign r_in  = '0;
			assign d_in  = den;
			assign sd_in = side;
		end else begin : g_next
			assign v_in  = v_s[j-1];
			assign w_in  = w_s[j-1];
			assign r_in  = r_s[j-1];
			assign d_in  = d_s[j-1];
			assign sd_in = sd_s[j-1];
		end

		assign trial = {r_in, w_in[NW-1]};
		assign ge    = trial >= {1'b0, d_in};
		assign diff  = trial - {1'b0, d_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[j] <= 1'b0;
			else if (en) v_s[j] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				w_s[j]  <= {w_in[NW-2:0], ge};
				r_s[j]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
				d_s[j]  <= d_in;
				sd_s[j] <= sd_in;
			end
		end
	end

	assign out_valid = v_s[NW-1];
	assign quo       = w_s[NW-1];
	assign rem       = r_s[NW-1];
	assign side_out  = sd_s[NW-1];

endmodule

FILE: hdl/lseg_effect.sv
// ----------------------------------------------------------------------------
// lseg_effect: effect evaluation, pixel store and output register
// Four stages work out the effect candidates, the last merges them with the
// stored pixel, writes the store and loads the output register.
// ----------------------------------------------------------------------------
module lseg_effect #(
	parameter int MAX_LEDS = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	output logic            clearing,
	input  lseg_pkg::cfg_t  cfg,
	input  logic            in_valid,
	input  lseg_pkg::fx_in_t fx,
	output logic            out_valid,
	output logic [7:0]      out_index,
	output logic [31:0]     out_rgbw,
	output logic            out_in_range
);

	import lseg_pkg::*;

	localparam int AW = $clog2(MAX_LEDS);

	typedef struct packed {
		logic [IDX_W-1:0] i;
		logic             rng;
		logic [1:0]       p_lo;
		logic             chase;
		logic             comet;
		logic             wset;
		logic             wclr;
		logic             thr;
	} flags_t;

	function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] i);
		logic [AW+IDX_W-1:0] ext;
		ext = {{AW{1'b0}}, i};
		return ext[AW-1:0];
	endfunction

	function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] t);
		logic [16:0] s;
		s = 17'(a) * (17'd256 - 17'(t)) + 17'(b) * 17'(t);
		return s[15:8];
	endfunction

	function automatic logic [7:0] scale8(input logic [7:0] c, input logic [7:0] k);
		logic [15:0] pr;
		pr = 16'(c) * 16'(k);
		return pr[15:8];
	endfunction

	function automatic logic [7:0] scale_comet(input logic [7:0] c, input logic [3:0] k);
		logic [11:0] pr;
		pr = 12'(c) * 12'(k);
		return pr[10:3];
	endfunction

	// ---------------- stage 1: positions, hits, hue
	logic [CNT_W-1:0] n;
	logic [9:0]       n10;
	logic [9:0]       i10;
	logic [9:0]       pos10;
	logic [9:0]       cd;
	logic [9:0]       cdm;
	logic [9:0]       md;
	logic [9:0]       mdm;
	logic             in_first;
	logic [2:0]       tsum;
	logic [17:0]      hsum;
	flags_t           fl_c;

	assign n   = cfg.n;
	assign n10 = {1'b0, n};
	assign i10 = {2'b00, fx.i};

	always_comb begin
		pos10    = (fx.f2n >= n10) ? fx.f2n - n10 : fx.f2n;
		cd       = i10 + n10 - pos10;
		cdm      = (cd >= n10) ? cd - n10 : cd;
		md       = pos10 + n10 - i10;
		mdm      = (md >= n10) ? md - n10 : md;
		in_first = fx.f2n < n10;
		tsum     = 3'(fx.im3) + 3'(fx.pm3);
		hsum     = 18'(fx.hq) + 18'(fx.pm36) * 18'(HUE_STEP);
		fl_c.i     = fx.i;
		fl_c.rng   = i10 < n10;
		fl_c.p_lo  = fx.p_lo;
		fl_c.chase = cdm < CHASE_LEN;
		fl_c.comet = mdm < 10'(COMET_LEN);
		fl_c.wset  = in_first && (i10 <= fx.f2n);
		fl_c.wclr  = !in_first && (i10 < fx.f2n - n10);
		fl_c.thr   = (tsum == 3'd0) || (tsum == 3'd3);
	end

	logic        v_s1;
	flags_t      fl_s1;
	logic [16:0] hue_s1;
	logic [7:0]  level_s1;
	logic [3:0]  cw_s1;
	logic [7:0]  tq_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fl_s1    <= fl_c;
			hue_s1   <= (hsum >= 18'(HUE_FULL)) ? 17'(hsum - 18'(HUE_FULL)) : hsum[16:0];
			level_s1 <= fx.level;
			cw_s1    <= COMET_LEN - mdm[3:0];
			tq_s1    <= fx.tq;
		end
	end

	// ---------------- stage 2: hue sector, color scaling, gradient
	logic [2:0]  sec_c;
	logic [16:0] base_c;
	logic [31:0] c;

	assign c = cfg.color;

	always_comb begin
		sec_c  = 3'd0;
		base_c = '0;
		for (int k = 1; k < 6; k++) begin
			if (hue_s1 >= 17'(k) * HUE_SECTOR) begin
				sec_c  = 3'(k);
				base_c = 17'(k) * HUE_SECTOR;
			end
		end
	end

	logic        v_s2;
	flags_t      fl_s2;
	logic [2:0]  sec_s2;
	logic [13:0] rem_s2;
	logic [23:0] brt_s2;
	logic [23:0] cmt_s2;
	logic [31:0] grd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fl_s2  <= fl_s1;
			sec_s2 <= sec_c;
			rem_s2 <= 14'(hue_s1 - base_c);
			brt_s2 <= {scale8(c[31:24], level_s1), scale8(c[23:16], level_s1),
				scale8(c[15:8], level_s1)};
			cmt_s2 <= {scale_comet(c[31:24], cw_s1), scale_comet(c[23:16], cw_s1),
				scale_comet(c[15:8], cw_s1)};
			grd_s2 <= {blend(c[31:24], ~c[31:24], tq_s1), blend(c[23:16], ~c[23:16], tq_s1),
				blend(c[15:8], ~c[15:8], tq_s1), blend(c[7:0], 8'd0, tq_s1)};
		end
	end

	// ---------------- stage 3: fraction within the sector
	logic [28:0] fprod;
	assign fprod = 29'(rem_s2) * 29'(RECIP_60);

	logic        v_s3;
	flags_t      fl_s3;
	logic [2:0]  sec_s3;
	logic [7:0]  f_s3;
	logic [23:0] brt_s3;
	logic [23:0] cmt_s3;
	logic [31:0] grd_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fl_s3  <= fl_s2;
			sec_s3 <= sec_s2;
			f_s3   <= fprod[27:20];
			brt_s3 <= brt_s2;
			cmt_s3 <= cmt_s2;
			grd_s3 <= grd_s2;
		end
	end

	// ---------------- stage 4: rainbow, merge with stored pixel
	logic        v_s4;
	flags_t      fl_s4;
	logic [2:0]  sec_s4;
	logic [7:0]  f_s4;
	logic [23:0] brt_s4;
	logic [23:0] cmt_s4;
	logic [31:0] grd_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fl_s4  <= fl_s3;
			sec_s4 <= sec_s3;
			f_s4   <= f_s3;
			brt_s4 <= brt_s3;
			cmt_s4 <= cmt_s3;
			grd_s4 <= grd_s3;
		end
	end

	logic [31:0] rdata;
	logic [31:0] old;
	logic        fwd_q;
	logic [31:0] fwd_px_q;
	logic [16:0] qm;
	logic [16:0] um;
	logic [7:0]  q8;
	logic [7:0]  u8;
	logic [31:0] rb;
	logic [31:0] px;

	assign old = fwd_q ? fwd_px_q : rdata;

	always_comb begin
		qm = ((17'd256 - 17'(f_s4)) << 8) - (17'd256 - 17'(f_s4));
		um = (17'(f_s4) << 8) - 17'(f_s4);
		q8 = qm[15:8];
		u8 = um[15:8];
		case (sec_s4)
			3'd0:    rb = {8'd255, u8, 8'd0, 8'd0};
			3'd1:    rb = {q8, 8'd255, 8'd0, 8'd0};
			3'd2:    rb = {8'd0, 8'd255, u8, 8'd0};
			3'd3:    rb = {8'd0, q8, 8'd255, 8'd0};
			3'd4:    rb = {u8, 8'd0, 8'd255, 8'd0};
			default: rb = {8'd255, 8'd0, q8, 8'd0};
		endcase
		case (cfg.mode)
			MODE_SOLID:    px = c;
			MODE_BLINK:    px = fl_s4.p_lo[1] ? 32'd0 : c;
			MODE_GRADIENT: px = grd_s4;
			MODE_RAINBOW:  px = rb;
			MODE_CHASE:    px = fl_s4.chase ? c : 32'd0;
			MODE_BREATHE:  px = {brt_s4, old[7:0]};
			MODE_STROBE:   px = fl_s4.p_lo[0] ? 32'd0 : c;
			MODE_COMET:    px = fl_s4.comet ? {cmt_s4, 8'd0} : 32'd0;
			MODE_WIPE:     px = fl_s4.wset ? c : (fl_s4.wclr ? 32'd0 : old);
			MODE_THEATER:  px = fl_s4.thr ? c : 32'd0;
			default:       px = old;
		endcase
	end

	// ---------------- pixel store with clearing pass after reset
	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;
	logic          we;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;

	assign clearing = clearing_q;
	assign we    = clearing_q || (en && v_s4 && fl_s4.rng);
	assign waddr = clearing_q ? clr_addr_q : to_addr(fl_s4.i);
	assign wdata = clearing_q ? 32'd0 : px;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(MAX_LEDS - 1)) clearing_q <= 1'b0;
		end
	end

	lseg_ram #(
		.WIDTH(32),
		.DEPTH(MAX_LEDS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (en),
		.raddr(to_addr(fl_s3.i)),
		.rdata(rdata)
	);

	// forward a write that lands on the address read in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fwd_q <= 1'b0;
		else if (en) fwd_q <= v_s4 && fl_s4.rng && (fl_s3.i == fl_s4.i);
	end

	always_ff @(posedge clk) begin
		if (en) fwd_px_q <= px;
	end

	// ---------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_index    <= fl_s4.i;
			out_rgbw     <= fl_s4.rng ? px : 32'd0;
			out_in_range <= fl_s4.rng;
		end
	end

	a_no_write_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!en && !clearing_q) |-> !we)
		else $error("pixel store written while pipeline held");

	a_fwd_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(en && !v_s4) |=> !fwd_q)
		else $error("forward taken from an empty stage");

endmodule

FILE: hdl/led_strip_effect_generator.sv
// ----------------------------------------------------------------------------
// led_strip_effect_generator: per-pixel addressable LED effect engine
// Takes a time and an LED index per request, derives the phase, evaluates
// one of ten effects, stores the pixel and returns its RGBW value.
// ----------------------------------------------------------------------------
//
//  channel   signals                                   direction
//  --------  ----------------------------------------  ---------
//  input     in_valid / in_stall, time_ms, led_index   in
//  output    out_valid / out_stall, out_index, red,    out
//            green, blue, white, in_range
//  config    APB: psel penable pwrite paddr pwdata     in/out
//            prdata pready
//
//  One request per cycle sustained while in_stall is low; a request passes
//  four front stages (register, angle and hue products, sine index, sine
//  lookup), a 32-stage phase divider, a 32-stage modulo divider, four effect
//  stages and the output register.
//  After reset the pixel store is cleared, one entry per cycle, through all
//  MAX_LEDS entries; in_stall stays high through that pass, config writes
//  still land. A held result (out_valid with out_stall) freezes the whole
//  pipeline and raises in_stall; nothing is dropped or repeated.
//
module led_strip_effect_generator #(
	parameter int MAX_LEDS     = 256,
	parameter int SINE_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] time_ms,
	input  logic [7:0]  led_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_index,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  white,
	output logic        in_range,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	import lseg_pkg::*;

	localparam int KW = $clog2(SINE_ENTRIES);

	// ---------------- configuration registers
	logic [3:0]       effect_mode_q;
	logic [31:0]      base_color_q;
	logic [15:0]      period_q;
	logic [CNT_W-1:0] led_count_q;
	logic             wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			effect_mode_q <= MODE_SOLID;
			base_color_q  <= 32'd0;
			period_q      <= 16'd100;
			led_count_q   <= 9'd256;
		end else if (wr) begin
			case (paddr[3:2])
				REG_MODE:   effect_mode_q <= pwdata[3:0];
				REG_COLOR:  base_color_q  <= pwdata;
				REG_PERIOD: period_q      <= pwdata[15:0];
				REG_COUNT:  led_count_q   <= pwdata[8:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MODE:   prdata = {28'd0, effect_mode_q};
			REG_COLOR:  prdata = base_color_q;
			REG_PERIOD: prdata = {16'd0, period_q};
			REG_COUNT:  prdata = {23'd0, led_count_q};
			default:    prdata = 32'd0;
		endcase
	end

	// zero period counts as one; strip length saturates to 8..MAX_LEDS
	logic [15:0]      per;
	logic [CNT_W-1:0] n_q;
	cfg_t             cfg;

	assign per = (period_q == 16'd0) ? 16'd1 : period_q;
	assign n_q = (led_count_q < 9'd8) ? 9'd8 :
		((32'(led_count_q) > 32'(MAX_LEDS)) ? CNT_W'(MAX_LEDS) : led_count_q);
	assign cfg = '{mode: effect_mode_q, color: base_color_q, n: n_q};

	// ---------------- flow control: one enable for the whole pipeline
	logic en;
	logic clearing;

	assign en       = !(out_valid && out_stall);
	assign in_stall = clearing || !en;

	// ---------------- sine table for breathe
	logic [7:0] sine_rom [SINE_ENTRIES];

	for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_rom
		localparam int     QUAD = (4 * g) / SINE_ENTRIES;
		localparam longint XF   = (longint'((4 * g) % SINE_ENTRIES) * 65536) / SINE_ENTRIES;
		assign sine_rom[g] = sine_entry(QUAD, XF);
	end

	// ---------------- front stages
	logic        v_s1, v_s2, v_s3, v_s4;
	logic [31:0] t_s1, t_s2, t_s3, t_s4;
	logic [7:0]  i_s1, i_s2, i_s3, i_s4;
	logic [31:0] ang_s2;
	logic [24:0] hnum_s2, hnum_s3, hnum_s4;
	logic [KW-1:0] k_s3;
	logic [7:0]  level_s4;
	logic [32+KW:0] kprod;

	assign kprod = (33 + KW)'(ang_s2) * (33 + KW)'(SINE_ENTRIES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid && !clearing;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1     <= time_ms;
			i_s1     <= led_index;
			t_s2     <= t_s1;
			i_s2     <= i_s1;
			ang_s2   <= t_s1 * BREATHE_STEP;
			hnum_s2  <= 25'(i_s1) * 25'(HUE_FULL);
			t_s3     <= t_s2;
			i_s3     <= i_s2;
			hnum_s3  <= hnum_s2;
			k_s3     <= kprod[31+KW:32];
			t_s4     <= t_s3;
			i_s4     <= i_s3;
			hnum_s4  <= hnum_s3;
			level_s4 <= sine_rom[k_s3];
		end
	end

	// ---------------- phase and per-LED ratios
	logic        d1_valid;
	logic [31:0] phase;
	logic [15:0] d1_side;
	logic [31:0] tq_full;
	logic [31:0] hq_full;

	lseg_div #(.NW(32), .DW(16), .SW(16)) u_div_phase (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s4), .num(t_s4), .den(per), .side({i_s4, level_s4}),
		.out_valid(d1_valid), .quo(phase), .rem(), .side_out(d1_side)
	);

	lseg_div #(.NW(32), .DW(CNT_W), .SW(1)) u_div_grad (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s4), .num({16'd0, i_s4, 8'd0}), .den(n_q), .side(1'b0),
		.out_valid(), .quo(tq_full), .rem(), .side_out()
	);

	lseg_div #(.NW(32), .DW(CNT_W), .SW(1)) u_div_hue (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s4), .num({7'd0, hnum_s4}), .den(n_q), .side(1'b0),
		.out_valid(), .quo(hq_full), .rem(), .side_out()
	);

	// ---------------- phase residues
	// p mod 2n runs through a divider; p mod 36, p mod 3 and i mod 3 fold
	// digits over two stages, then ride a delay line alongside that divider
	localparam int RES_DLY = 31;

	function automatic logic [3:0] mod9(input logic [6:0] x);
		logic [3:0] r;
		r = x[3:0];
		for (int k = 1; k < 8; k++) begin
			if (x >= 7'(9 * k)) r = 4'(x - 7'(9 * k));
		end
		return r;
	endfunction

	function automatic logic [1:0] mod3(input logic [3:0] x);
		logic [1:0] r;
		r = x[1:0];
		for (int k = 1; k < 5; k++) begin
			if (x >= 4'(3 * k)) r = 2'(x - 4'(3 * k));
		end
		return r;
	endfunction

	logic        d2_valid;
	logic [42:0] d2_side;
	logic [9:0]  f2n;
	logic [5:0]  pm36;
	logic [1:0]  pm3;
	logic [1:0]  im3;
	logic [8:0]  dsum_s1;
	logic [1:0]  plo_s1;
	logic [3:0]  isum_s1;
	logic [6:0]  fold;
	logic [3:0]  pm9;
	logic [9:0]  res_s [RES_DLY];

	assign fold = 7'(dsum_s1[8:6]) + 7'(dsum_s1[5:0]);
	assign pm9  = mod9(fold);

	always_ff @(posedge clk) begin
		if (en) begin
			// 64 is 1 mod 9: sum the six-bit digits of p >> 2
			dsum_s1  <= 9'(phase[7:2]) + 9'(phase[13:8]) + 9'(phase[19:14]) +
				9'(phase[25:20]) + 9'(phase[31:26]);
			plo_s1   <= phase[1:0];
			// 4 is 1 mod 3: sum the two-bit digits of the index
			isum_s1  <= 4'(d1_side[9:8]) + 4'(d1_side[11:10]) + 4'(d1_side[13:12]) +
				4'(d1_side[15:14]);
			res_s[0] <= {pm9, plo_s1, mod3(4'(pm9) + 4'(plo_s1)), mod3(isum_s1)};
			for (int k = 1; k < RES_DLY; k++) res_s[k] <= res_s[k-1];
		end
	end

	assign pm36 = res_s[RES_DLY-1][9:4];
	assign pm3  = res_s[RES_DLY-1][3:2];
	assign im3  = res_s[RES_DLY-1][1:0];

	lseg_div #(.NW(32), .DW(10), .SW(43)) u_mod_2n (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(d1_valid), .num(phase), .den({n_q, 1'b0}),
		.side({d1_side, phase[1:0], tq_full[7:0], hq_full[16:0]}),
		.out_valid(d2_valid), .quo(), .rem(f2n), .side_out(d2_side)
	);

	fx_in_t fx;
	assign fx = '{i: d2_side[42:35], level: d2_side[34:27], p_lo: d2_side[26:25],
		tq: d2_side[24:17], hq: d2_side[16:0], f2n: f2n, pm36: pm36, pm3: pm3, im3: im3};

	// ---------------- effect stages, pixel store, output register
	logic [31:0] rgbw;

	lseg_effect #(.MAX_LEDS(MAX_LEDS)) u_effect (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.clearing    (clearing),
		.cfg         (cfg),
		.in_valid    (d2_valid),
		.fx          (fx),
		.out_valid   (out_valid),
		.out_index   (out_index),
		.out_rgbw    (rgbw),
		.out_in_range(in_range)
	);

	assign red   = rgbw[31:24];
	assign green = rgbw[23:16];
	assign blue  = rgbw[15:8];
	assign white = rgbw[7:0];

	a_oor_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !in_range) |-> (red == 8'd0 && green == 8'd0 &&
		blue == 8'd0 && white == 8'd0))
		else $error("out of range result carries color");

	a_range_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && in_range) |-> ({1'b0, out_index} < n_q))
		else $error("in_range set for index beyond strip");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |=> !v_s1)
		else $error("request entered during clearing pass");

endmodule

FILE: test/led_strip_effect_generator_tb.sv
// ----------------------------------------------------------------------------
// led_strip_effect_generator_tb: self-checking bench of the LED effect engine
// Drives pixel requests under changing register settings and idle patterns,
// predicts every pixel with an in-bench model of the effects and the pixel
// store, and compares each returned pixel with the oldest prediction.
// ----------------------------------------------------------------------------
module led_strip_effect_generator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lseg_pkg::*;

	typedef struct packed {
		logic [7:0] idx;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] w;
		logic       hit;
	} pixel_t;

	// Pixel predictor plus the queue of pixels still owed by the block.
	class pixel_scoreboard;
		logic [3:0]  mode;
		logic [31:0] color;
		logic [15:0] period;
		logic [8:0]  count;
		logic [31:0] store [256];
		logic [7:0]  breath_lut [256];
		pixel_t      owed [$];
		int          errors;

		function new();
			longint x, x2, r, s, e;
			int quad;
			mode = MODE_SOLID;
			color = 0;
			period = 100;
			count = 256;
			errors = 0;
			foreach (store[k]) store[k] = 0;
			// quarter-wave polynomial sine, offset to 0..255
			for (int k = 0; k < 256; k++) begin
				quad = (4 * k) / 256;
				x = (((4 * k) % 256) * 65536) / 256;
				if (quad % 2 == 1) x = 65536 - x;
				x2 = (x * x) / 65536;
				r = 11;
				r = -307 + (r * x2) / 65536;
				r = 5223 + (r * x2) / 65536;
				r = -42334 + (r * x2) / 65536;
				r = 102944 + (r * x2) / 65536;
				s = (r * x) / 65536;
				if (s < 0) s = 0;
				if (s > 65536) s = 65536;
				if (quad >= 2) s = -s;
				e = ((65536 + s) * 128) >>> 16;
				breath_lut[k] = (e > 255) ? 8'd255 : 8'(e);
			end
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] v);
			case (idx)
				REG_MODE:   mode = v[3:0];
				REG_COLOR:  color = v;
				REG_PERIOD: period = v[15:0];
				REG_COUNT:  count = v[8:0];
				default:    ;
			endcase
		endfunction

		function logic [31:0] scale_rgb(logic [31:0] c, int unsigned num, int sh,
				logic [7:0] w);
			logic [7:0] rr, gg, bb;
			rr = 8'((c[31:24] * num) >> sh);
			gg = 8'((c[23:16] * num) >> sh);
			bb = 8'((c[15:8] * num) >> sh);
			return {rr, gg, bb, w};
		endfunction

		function logic [31:0] hue_color(int unsigned i, int unsigned n, int unsigned p);
			int unsigned hue, sec, f, q, u;
			hue = (i * 92160) / n + (p % 36) * 2560;
			if (hue >= 92160) hue -= 92160;
			sec = hue / 15360;
			f = (hue % 15360) / 60;
			q = (255 * (256 - f)) >> 8;
			u = (255 * f) >> 8;
			case (sec)
				0: return {8'd255, 8'(u), 8'd0, 8'd0};
				1: return {8'(q), 8'd255, 8'd0, 8'd0};
				2: return {8'd0, 8'd255, 8'(u), 8'd0};
				3: return {8'd0, 8'(q), 8'd255, 8'd0};
				4: return {8'(u), 8'd0, 8'd255, 8'd0};
				default: return {8'd255, 8'd0, 8'(q), 8'd0};
			endcase
		endfunction

		function int unsigned mix(int unsigned a, int unsigned b, int unsigned t);
			return (a * (256 - t) + b * t) >> 8;
		endfunction

		// Predict the pixel for one accepted request and update the store.
		function void note(logic [31:0] t, logic [7:0] i);
			int unsigned n, p, pos, d, f, tq;
			logic [63:0] ang;
			logic [31:0] px;
			pixel_t e;
			n = count;
			if (n < 8) n = 8;
			if (n > 256) n = 256;
			p = t / ((period == 0) ? 32'd1 : 32'(period));
			e = '0;
			e.idx = i;
			if (i < n) begin
				px = store[i];
				case (mode)
					MODE_SOLID:    px = color;
					MODE_BLINK:    px = p[1] ? 32'd0 : color;
					MODE_STROBE:   px = p[0] ? 32'd0 : color;
					MODE_GRADIENT: begin
						tq = (i * 256) / n;
						px = {8'(mix(color[31:24], 255 - color[31:24], tq)),
							8'(mix(color[23:16], 255 - color[23:16], tq)),
							8'(mix(color[15:8], 255 - color[15:8], tq)),
							8'(mix(color[7:0], 0, tq))};
					end
					MODE_RAINBOW:  px = hue_color(i, n, p);
					MODE_CHASE: begin
						pos = p % n;
						px = (((i + n - pos) % n) < 3) ? color : 32'd0;
					end
					MODE_BREATHE: begin
						ang = 64'(t) * 64'(BREATHE_STEP);
						px = scale_rgb(color, breath_lut[ang[31:24]], 8, store[i][7:0]);
					end
					MODE_COMET: begin
						pos = p % n;
						d = (pos + n - i) % n;
						px = (d < 8) ? scale_rgb(color, 8 - d, 3, 8'd0) : 32'd0;
					end
					MODE_WIPE: begin
						f = p % (2 * n);
						if (f < n) begin
							if (i <= f) px = color;
						end else if (i < f - n) begin
							px = 32'd0;
						end
					end
					MODE_THEATER:  px = (((i % 3) + (p % 3)) % 3 == 0) ? color : 32'd0;
					default: ;
				endcase
				store[i] = px;
				{e.r, e.g, e.b, e.w} = px;
				e.hit = 1'b1;
			end
			owed.push_back(e);
		endfunction

		function void check(pixel_t got);
			pixel_t e;
			if (owed.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected pixel %h", got);
				return;
			end
			e = owed.pop_front();
			if (got !== e) begin
				errors++;
				if (errors <= 10)
					$display("pixel mismatch idx/r/g/b/w/hit exp %h %h %h %h %h %b got %h %h %h %h %h %b",
						e.idx, e.r, e.g, e.b, e.w, e.hit,
						got.idx, got.r, got.g, got.b, got.w, got.hit);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] time_ms;
	logic [7:0]  led_index;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_index, red, green, blue, white;
	logic        in_range;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	pixel_scoreboard sb = new();
	int gap_pct = 0;
	int stall_pct = 0;
	int idle_cycles = 0;

	led_strip_effect_generator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .time_ms(time_ms), .led_index(led_index),
		.out_valid(out_valid), .out_stall(out_stall), .out_index(out_index),
		.red(red), .green(green), .blue(blue), .white(white), .in_range(in_range),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver: randomly hold back results, changing only at the falling edge.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall = ($urandom_range(99) < stall_pct);
		end
	end

	// Check every pixel handed over, and watch for a hang.
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check({out_index, red, green, blue, white, in_range});
		if ((out_valid && !out_stall) || (in_valid && !in_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("led_strip_effect_generator verification failed");
			$finish;
		end
	end

	// Write one register: setup cycle, then access cycle; called at a falling edge.
	task reg_write(logic [1:0] idx, logic [31:0] v);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, v);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Offer one request, hold it until taken; called at a falling edge.
	task send_pixel(logic [31:0] t, logic [7:0] i);
		while ($urandom_range(99) < gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		time_ms = t;
		led_index = i;
		do @(posedge clk); while (in_stall);
		sb.note(t, i);
		@(negedge clk);
	endtask

	// Pause the sender until every owed pixel is back, then let the pipe drain.
	task drain();
		in_valid = 1'b0;
		while (sb.owed.size() > 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	function logic [31:0] pick_time();
		case ($urandom_range(5))
			0: return 32'hFFFF_FFFF - $urandom_range(3000);
			1, 2: return $urandom_range(20000);
			default: return $urandom();
		endcase
	endfunction

	initial begin
		int n_eff;
		logic [7:0] idx;
		arst_n = 1'b0;
		in_valid = 1'b0;
		time_ms = '0;
		led_index = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset settings, time and index extremes (index beyond strip on 255
		// only after the count shrinks).
		send_pixel(32'd0, 8'd0);
		send_pixel(32'hFFFF_FFFF, 8'd255);
		send_pixel(32'd12345, 8'd128);
		drain();
		reg_write(REG_MODE, 32'(MODE_BREATHE));
		reg_write(REG_COLOR, 32'hFFFF_FFFF);
		reg_write(REG_PERIOD, 32'd0);
		reg_write(REG_COUNT, 32'd0);
		send_pixel(32'd0, 8'd0);
		send_pixel(32'hFFFF_FFFF, 8'd7);
		send_pixel(32'd523, 8'd8);
		send_pixel(32'd1000, 8'd255);
		drain();
		reg_write(REG_COUNT, 32'd511);
		reg_write(REG_PERIOD, 32'd65535);
		send_pixel(32'hFFFF_FFFF, 8'd255);
		send_pixel(32'd0, 8'd3);
		drain();

		// Walk all sixteen mode codes first, then random settings.
		for (int ph = 0; ph < 40; ph++) begin
			case (ph % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 87; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 87; end
				default: begin gap_pct = 16; stall_pct = 16; end
			endcase
			drain();
			reg_write(REG_MODE, (ph < 16) ? 32'(ph) : $urandom_range(9));
			case ($urandom_range(3))
				0: reg_write(REG_COLOR, 32'd0);
				1: reg_write(REG_COLOR, 32'hFFFF_FFFF);
				default: reg_write(REG_COLOR, $urandom());
			endcase
			case ($urandom_range(5))
				0: reg_write(REG_PERIOD, 32'd0);
				1: reg_write(REG_PERIOD, 32'd65535);
				2: reg_write(REG_PERIOD, $urandom());
				default: reg_write(REG_PERIOD, $urandom_range(1, 20));
			endcase
			case ($urandom_range(6))
				0: reg_write(REG_COUNT, $urandom_range(0, 8));
				1: reg_write(REG_COUNT, 32'd256);
				2: reg_write(REG_COUNT, $urandom_range(257, 511));
				default: reg_write(REG_COUNT, $urandom_range(9, 255));
			endcase
			n_eff = (sb.count < 8) ? 8 : (sb.count > 256) ? 256 : sb.count;
			for (int k = 0; k < 44; k++) begin
				// mostly pixels on the strip, a few at random indexes that may lie past its end
				if ($urandom_range(9) < 8) idx = 8'($urandom_range(n_eff - 1));
				else idx = 8'($urandom());
				send_pixel(pick_time(), idx);
			end
		end
		drain();
		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("led_strip_effect_generator verification clean");
		else
			$display("led_strip_effect_generator verification failed");
		$finish;
	end

endmodule
